// ----- hw/rtl/sfc_pkg.sv -----
// Package: constants and result type for the serial frame checker.
package sfc_pkg;

    // CRC-16/CCITT-FALSE parameters
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // Frame layout
    localparam logic [16:0] POS_MAX        = 17'h1FFFF;
    localparam logic [16:0] HDR_BYTES      = 17'd3;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd6;
    localparam logic [7:0]  SYNC_RESET     = 8'h7E;

    // One result transaction
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_end;
        logic        frame_good;
        logic [15:0] payload_count;
    } sfc_result_t;

endpackage

// ----- hw/rtl/sfc_if.sv -----
// Interfaces: input byte channel and result channel, valid/ready handshake.
interface sfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface sfc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic        frame_good;
    logic [15:0] payload_count;

    modport source (output valid, output out_byte, output frame_end,
                    output frame_good, output payload_count, input ready);
    modport sink   (input valid, input out_byte, input frame_end,
                    input frame_good, input payload_count, output ready);
endinterface

// ----- hw/rtl/sfc_crc_byte.sv -----
// Module: byte-wide CRC-16/CCITT-FALSE update, eight bit steps unrolled.
module sfc_crc_byte
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);
    import sfc_pkg::*;

    // Shift the byte through the polynomial MSB first
    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

// ----- hw/rtl/serial_frame_checker.sv -----
// Serial frame checker: one byte per cycle while in_ch.ready is high, result registered.
// A payload byte or closing status is registered in the output stage before out_ch shows it.
// Throughput: one byte per cycle while the skid entry is empty; the frame state and CRC
// update on each accepted byte, and a two-entry output stage (register plus skid) lets input
// take one more result while a result waits; ready is low while the skid is full.
// Reset (rst_n low, async) clears frame state and output stage, sets sync_reg to 0x7E.
module serial_frame_checker
(
    input  logic         clk,
    input  logic         rst_n,
    sfc_in_if.sink       in_ch,
    sfc_out_if.source    out_ch,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data
);
    import sfc_pkg::*;

    logic [7:0]  sync_reg;
    logic [16:0] pos_reg,  pos_next;
    logic [15:0] len_reg,  len_next;
    logic [15:0] crc_reg,  crc_next;
    logic [15:0] fcs_reg,  fcs_next;
    logic        bad_reg,  bad_next;

    sfc_result_t out_reg,  skid_reg,  res_next;
    logic        out_valid_reg, skid_valid_reg, res_valid;

    logic        in_acc, out_take;
    logic [7:0]  b;
    logic [16:0] cov_end, len_ext;
    logic [15:0] crc_byte;
    logic        crc_upd, good;

    assign b        = in_ch.byte_value;
    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_take = out_valid_reg && out_ch.ready;
    assign in_ch.ready = !skid_valid_reg;

    sfc_crc_byte u_crc
    (
        .crc_in  (crc_reg),
        .data    (b),
        .crc_out (crc_byte)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_RESET;
        end
        else if (cfg_wr_en)
        begin
            sync_reg <= cfg_wr_data;
        end
    end

    // Frame state update and result for the byte on the input
    always_comb
    begin
        cov_end = {1'b0, len_reg} + HDR_BYTES;

        bad_next = bad_reg || (pos_reg == 17'd0 && b != sync_reg);

        len_next = len_reg;
        if (pos_reg == 17'd1)
        begin
            len_next = {b, len_reg[7:0]};
        end
        else if (pos_reg == 17'd2)
        begin
            len_next = {len_reg[15:8], b};
        end
        len_ext = {1'b0, len_next} + FRAME_OVERHEAD;

        crc_upd  = (pos_reg < HDR_BYTES) || (pos_reg < cov_end);
        crc_next = crc_upd ? crc_byte : crc_reg;

        fcs_next = fcs_reg;
        if (pos_reg >= HDR_BYTES && pos_reg == cov_end)
        begin
            fcs_next = {b, fcs_reg[7:0]};
        end
        else if (pos_reg >= HDR_BYTES && pos_reg == cov_end + 17'd1)
        begin
            fcs_next = {fcs_reg[15:8], b};
        end

        good = !bad_next && (b == sync_reg) && (pos_reg != POS_MAX)
            && (pos_reg + 17'd1 == len_ext) && (fcs_next == crc_next);

        pos_next  = (pos_reg != POS_MAX) ? pos_reg + 17'd1 : pos_reg;
        res_next  = '0;
        res_valid = 1'b0;
        if (in_ch.last_byte)
        begin
            // closing status, then start over
            res_valid              = 1'b1;
            res_next.frame_end     = 1'b1;
            res_next.frame_good    = good;
            res_next.payload_count = good ? len_next : 16'h0000;
            pos_next = '0;
            len_next = '0;
            crc_next = CRC_INIT;
            fcs_next = '0;
            bad_next = 1'b0;
        end
        else if (pos_reg >= HDR_BYTES && pos_reg < cov_end)
        begin
            // payload byte passes through
            res_valid         = 1'b1;
            res_next.out_byte = b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
            crc_reg <= CRC_INIT;
            fcs_reg <= '0;
            bad_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            crc_reg <= crc_next;
            fcs_reg <= fcs_next;
            bad_reg <= bad_next;
        end
    end

    // Output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_reg <= in_acc && res_valid;
        end
        else if (in_acc && res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_reg <= res_next;
        end
        else
        begin
            skid_reg <= res_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_byte      = out_reg.out_byte;
    assign out_ch.frame_end     = out_reg.frame_end;
    assign out_ch.frame_good    = out_reg.frame_good;
    assign out_ch.payload_count = out_reg.payload_count;

`ifndef SYNTHESIS
    // skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // a closing byte restarts the frame
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_ch.last_byte |=> pos_reg == 17'd0 && crc_reg == CRC_INIT && !bad_reg)
        else $error("frame state not cleared after closing byte");

    // a rejected frame reports no length
    a_bad_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.frame_good |-> out_reg.payload_count == 16'h0000)
        else $error("payload count on rejected result");

    // payload transactions carry no status
    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.frame_end |-> !out_reg.frame_good)
        else $error("status bit set on payload transaction");
`endif

endmodule
